FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: shared assertion macros
// wraps concurrent assertions so that synthesis sees nothing of them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication whose consequent is checked in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

FILE: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: json string unescape package
// transfer types, status codes and queue sizing shared by the unit
// ----------------------------------------------------------------------------
package jsu_pkg;

   // result status codes
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // queue between decoder and emitter
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
   localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } jsu_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       last;
   } jsu_rsp_type;

   // decoded work for one input: one to three results
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count_m1;
      logic            byte_valid;
      logic [1:0]      status;
   } jsu_pkt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_q_status_type;

endpackage

FILE: rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: string decoder front end
// classifies each input byte, tracks escape state and builds a result packet
// ----------------------------------------------------------------------------
module jsu_front
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  jsu_req_type req,
   output jsu_pkt_type pkt
);

   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_STR  = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;
   localparam logic [1:0] MODE_HEX  = 2'd3;

   localparam logic [15:0] CP_MAX1 = 16'h007F;
   localparam logic [15:0] CP_MAX2 = 16'h07FF;

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;
   logic [15:0] cp_ff, cp_in;

   logic [7:0]  c;
   logic        fin;
   logic        is_ws;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_next;

   assign c   = req.in_byte;
   assign fin = req.is_last;
   assign is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);

   // hex digit decode
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cp_next = {cp_ff[11:0], hex_val};

   always_comb begin
      mode_in        = mode_ff;
      hex_cnt_in     = hex_cnt_ff;
      cp_in          = cp_ff;
      pkt.bytes      = '0;
      pkt.count_m1   = 2'd0;
      pkt.byte_valid = 1'b0;
      pkt.status     = ST_BUSY;
      unique case (mode_ff)
         MODE_WAIT: begin
            if (is_ws && !fin) begin
               // skip leading whitespace
            end else if (c == 8'h22 && !fin) begin
               mode_in = MODE_STR;
            end else begin
               pkt.status = ST_ERR;
            end
         end
         MODE_STR: begin
            if (c == 8'h22) begin
               mode_in    = MODE_WAIT;
               pkt.status = ST_DONE;
            end else if (c < 8'h20 || fin) begin
               pkt.status = ST_ERR;
            end else if (c == 8'h5C) begin
               mode_in = MODE_ESC;
            end else begin
               pkt.bytes[0]   = c;
               pkt.byte_valid = 1'b1;
            end
         end
         MODE_ESC: begin
            mode_in        = MODE_STR;
            pkt.byte_valid = 1'b1;
            case (c)
               8'h22, 8'h5C, 8'h2F: pkt.bytes[0] = c;
               8'h62: pkt.bytes[0] = 8'h08;
               8'h66: pkt.bytes[0] = 8'h0C;
               8'h6E: pkt.bytes[0] = 8'h0A;
               8'h72: pkt.bytes[0] = 8'h0D;
               8'h74: pkt.bytes[0] = 8'h09;
               8'h75: begin
                  mode_in        = MODE_HEX;
                  hex_cnt_in     = 2'd0;
                  cp_in          = 16'd0;
                  pkt.byte_valid = 1'b0;
               end
               default: pkt.status = ST_ERR;
            endcase
            if (fin) begin
               pkt.status = ST_ERR;
            end
         end
         MODE_HEX: begin
            if (!hex_ok || fin) begin
               pkt.status = ST_ERR;
            end else if (hex_cnt_ff != 2'd3) begin
               hex_cnt_in = hex_cnt_ff + 2'd1;
               cp_in      = cp_next;
            end else begin
               // fourth digit: emit the code point as utf-8
               mode_in        = MODE_STR;
               hex_cnt_in     = 2'd0;
               cp_in          = cp_next;
               pkt.byte_valid = 1'b1;
               if (cp_next <= CP_MAX1) begin
                  pkt.bytes[0] = cp_next[7:0];
               end else if (cp_next <= CP_MAX2) begin
                  pkt.bytes[0]  = {3'b110, cp_next[10:6]};
                  pkt.bytes[1]  = {2'b10, cp_next[5:0]};
                  pkt.count_m1  = 2'd1;
               end else begin
                  pkt.bytes[0]  = {4'b1110, cp_next[15:12]};
                  pkt.bytes[1]  = {2'b10, cp_next[11:6]};
                  pkt.bytes[2]  = {2'b10, cp_next[5:0]};
                  pkt.count_m1  = 2'd2;
               end
            end
         end
         default: begin
            mode_in = MODE_WAIT;
         end
      endcase
      // any error drops decoded bytes and returns to waiting
      if (pkt.status == ST_ERR) begin
         mode_in        = MODE_WAIT;
         hex_cnt_in     = 2'd0;
         cp_in          = 16'd0;
         pkt.bytes      = '0;
         pkt.count_m1   = 2'd0;
         pkt.byte_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAIT;
         hex_cnt_ff <= 2'd0;
         cp_ff      <= 16'd0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         cp_ff      <= cp_in;
      end
   end

endmodule

FILE: rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: packet queue
// small fifo that decouples the decoder from the result emitter
// ----------------------------------------------------------------------------
module jsu_queue
   import jsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkt_type      push_pkt,
   input  logic             pop,
   output jsu_pkt_type      head_pkt,
   output jsu_q_status_type q_status
);

   jsu_pkt_type          mem_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == QCntWidth'(QueueDepth));
   assign q_status.empty = (count_ff == '0);
   assign head_pkt       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result emitter
// walks the head packet one result per cycle, unless stalled, into the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back
   import jsu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkt_type      head_pkt,
   input  jsu_q_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jsu_rsp_type      rsp_data
);

   logic        out_valid_ff, out_valid_in;
   jsu_rsp_type out_ff, out_in;
   logic [1:0]  idx_ff, idx_in;
   logic        load;
   logic        is_last;

   assign load    = !q_status.empty && (!out_valid_ff || !rsp_stall);
   assign is_last = (idx_ff == head_pkt.count_m1);
   assign pop     = load && is_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in      = 1'b1;
         out_in.out_byte   = head_pkt.bytes[idx_ff];
         out_in.byte_valid = head_pkt.byte_valid;
         out_in.status     = head_pkt.status;
         out_in.last       = is_last;
         idx_in            = is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // a status report is always a single result without a byte
   `ASSERT_CLK(a_status_single, clock, reset,
      !out_valid_ff || out_ff.status == ST_BUSY || (out_ff.last && !out_ff.byte_valid))
   // no byte means a zero payload byte
   `ASSERT_CLK(a_empty_zero, clock, reset,
      !out_valid_ff || out_ff.byte_valid || out_ff.out_byte == 8'd0)
   // the rest of a multi-byte sequence follows without a gap
   `ASSERT_NEXT(a_seq_cont, clock, reset,
      out_valid_ff && !rsp_stall && !out_ff.last, out_valid_ff)

endmodule

FILE: rtl/core/json_string_unescape_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_unit: streaming json string decoder
// one text byte per transfer in, decoded utf-8 bytes and status out
// ----------------------------------------------------------------------------
// usage
//   req channel: one byte of json text per transfer, is_last on the final
//   byte of a buffer. rsp channel: one to three result transfers per input
//   byte, last set on the final one; status busy, string closed or error
// path
//   a result is written into the packet queue at its input transfer and
//   loaded from there into the output register before it is on the port
// throughput
//   one input per cycle while the queue has room, one result per cycle
//   unless stalled; a \u escape that yields two or three utf-8 bytes emits
//   them in turn, and the four-entry packet queue absorbs the difference
// reset
//   synchronous; clears the decoder to waiting for an opening quote and
//   empties the queue and the output register
// stall
//   rsp_stall holds the output register; the queue fills and req_stall
//   rises once it is full, without losing or repeating a result
// ----------------------------------------------------------------------------
module json_string_unescape_unit
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  jsu_req_type req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output jsu_rsp_type rsp_data
);

   logic             req_accept;
   jsu_pkt_type      front_pkt;
   jsu_pkt_type      head_pkt;
   jsu_q_status_type q_status;
   logic             pop;

   // input transfer whenever the queue has room
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !q_status.full;

   // decoder: state machine for quotes, escapes and hex digits
   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .pkt    (front_pkt)
   );

   // packets of one to three results wait here
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_pkt (front_pkt),
      .pop      (pop),
      .head_pkt (head_pkt),
      .q_status (q_status)
   );

   // emitter: one result per cycle into the output register unless stalled
   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_pkt  (head_pkt),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker: result checker for the json string unescape unit
// watches both channels, decodes every accepted text byte on its own and
// compares each accepted result with the oldest outstanding one
// ----------------------------------------------------------------------------
module jsu_checker
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  jsu_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  jsu_rsp_type rsp_data,
   output int          mismatch_count,
   output int          results_pending,
   output int          text_bytes,
   output int          decoded_bytes,
   output int          strings_closed,
   output int          syntax_errors
);

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [1:0] {
      WAIT_QUOTE,
      IN_STRING,
      AFTER_ESCAPE,
      IN_HEX
   } scan_mode_type;

   scan_mode_type scan_mode;
   logic [1:0]  hex_digits_taken;
   logic [15:0] code_point_acc;
   jsu_rsp_type decoded_results[$];
   jsu_rsp_type oldest;
   int          results_seen;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("mismatch at result %0d: %s", results_seen, what);
      end
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
      end
   endtask

   task automatic push_status(input logic [1:0] status);
      jsu_rsp_type entry;
      entry = '{out_byte: 8'h00, byte_valid: 1'b0, status: status, last: 1'b1};
      decoded_results.insert(decoded_results.size(), entry);
   endtask

   task automatic push_bytes(input logic [2:0][7:0] bytes, input int count);
      jsu_rsp_type entry;
      for (int k = 0; k < count; k++) begin
         entry = '{out_byte: bytes[k], byte_valid: 1'b1,
                   status: ST_BUSY, last: (k == count - 1)};
         decoded_results.insert(decoded_results.size(), entry);
      end
      decoded_bytes += count;
   endtask

   // any syntax error drops the string and goes back to waiting
   task automatic abort_string();
      scan_mode        = WAIT_QUOTE;
      hex_digits_taken = 2'd0;
      code_point_acc   = 16'h0000;
      syntax_errors++;
      push_status(ST_ERR);
   endtask

   function automatic int digit_value(input logic [7:0] c);
      if (c inside {["0":"9"]}) return int'(c) - int'("0");
      if (c inside {["a":"f"]}) return int'(c) - int'("a") + 10;
      if (c inside {["A":"F"]}) return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   task automatic decode_byte(input jsu_req_type item);
      logic [7:0]      c;
      logic            fin;
      int              digit;
      logic [15:0]     cp;
      logic [2:0][7:0] utf8;
      c    = item.in_byte;
      fin  = item.is_last;
      utf8 = '0;
      text_bytes++;
      case (scan_mode)
         WAIT_QUOTE: begin
            if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
               if (fin) abort_string();
               else push_status(ST_BUSY);
            end else if (c != CH_QUOTE || fin) begin
               abort_string();
            end else begin
               scan_mode = IN_STRING;
               push_status(ST_BUSY);
            end
         end
         IN_STRING: begin
            if (c == CH_QUOTE) begin
               scan_mode = WAIT_QUOTE;
               strings_closed++;
               push_status(ST_DONE);
            end else if (c < 8'h20 || fin) begin
               abort_string();
            end else if (c == CH_BSLASH) begin
               scan_mode = AFTER_ESCAPE;
               push_status(ST_BUSY);
            end else begin
               utf8[0] = c;
               push_bytes(utf8, 1);
            end
         end
         AFTER_ESCAPE: begin
            if (fin) begin
               abort_string();
            end else if (c == "u") begin
               scan_mode        = IN_HEX;
               hex_digits_taken = 2'd0;
               code_point_acc   = 16'h0000;
               push_status(ST_BUSY);
            end else if (c inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"}) begin
               case (c)
                  "b":     utf8[0] = 8'h08;
                  "f":     utf8[0] = 8'h0C;
                  "n":     utf8[0] = CH_LF;
                  "r":     utf8[0] = CH_CR;
                  "t":     utf8[0] = CH_TAB;
                  default: utf8[0] = c;
               endcase
               scan_mode = IN_STRING;
               push_bytes(utf8, 1);
            end else begin
               abort_string();
            end
         end
         default: begin
            digit = digit_value(c);
            if (digit < 0 || fin) begin
               abort_string();
            end else begin
               cp             = {code_point_acc[11:0], 4'(digit)};
               code_point_acc = cp;
               if (hex_digits_taken != 2'd3) begin
                  hex_digits_taken++;
                  push_status(ST_BUSY);
               end else begin
                  scan_mode        = IN_STRING;
                  hex_digits_taken = 2'd0;
                  if (cp <= 16'h007F) begin
                     utf8[0] = cp[7:0];
                     push_bytes(utf8, 1);
                  end else if (cp <= 16'h07FF) begin
                     utf8[0] = {3'b110, cp[10:6]};
                     utf8[1] = {2'b10, cp[5:0]};
                     push_bytes(utf8, 2);
                  end else begin
                     utf8[0] = {4'b1110, cp[15:12]};
                     utf8[1] = {2'b10, cp[11:6]};
                     utf8[2] = {2'b10, cp[5:0]};
                     push_bytes(utf8, 3);
                  end
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_mode        = WAIT_QUOTE;
         hex_digits_taken = 2'd0;
         code_point_acc   = 16'h0000;
         decoded_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (decoded_results.size() == 0) begin
               report_mismatch("result arrived with nothing outstanding");
            end else begin
               oldest = decoded_results.pop_front();
               compare_field("out_byte", rsp_data.out_byte, oldest.out_byte);
               compare_field("byte_valid", rsp_data.byte_valid, oldest.byte_valid);
               compare_field("status", rsp_data.status, oldest.status);
               compare_field("last", rsp_data.last, oldest.last);
            end
         end
      end
      results_pending <= decoded_results.size();
   end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: json string unescape unit
// drives directed and random json text, with well-formed strings, broken
// strings and noise, under random gaps and result back-pressure; a separate
// checker decodes the same text and compares every result transfer
// ----------------------------------------------------------------------------
module testbench
   import jsu_pkg::*;
();

   localparam int RANDOM_ITEMS   = 200;
   localparam int WATCHDOG_LIMIT = 500;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES   = 10;    // margin after no result is pending

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   jsu_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   jsu_rsp_type rsp_data;

   int mismatch_count;
   int results_pending;
   int text_bytes;
   int decoded_bytes;
   int strings_closed;
   int syntax_errors;

   // per-string switches for stretches without any idling
   bit req_no_idle = 1'b0;
   bit rsp_no_idle = 1'b0;

   int items_sent;
   int idle_cycles;
   int rsp_hold_left;
   int rsp_hold_draw;

   // whitespace allowed before a string
   logic [7:0] blank_bytes [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
   // letters that form a single-byte escape
   string escape_letters = "\"\\/bfnrt";

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_string_unescape_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   jsu_checker data_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .text_bytes      (text_bytes),
      .decoded_bytes   (decoded_bytes),
      .strings_closed  (strings_closed),
      .syntax_errors   (syntax_errors)
   );

   // result side: after each result transfer, maybe hold stall for a random time
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_hold_draw = rsp_no_idle ? 0 : $urandom_range(0, 9);
         rsp_hold_left <= rsp_hold_draw;
         rsp_stall     <= (rsp_hold_draw != 0);
      end else if (rsp_hold_left > 1) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_hold_left <= 0;
         rsp_stall     <= 1'b0;
      end
   end

   // watchdog: ends the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // one text byte: random gap first, then hold valid until the transfer
   task automatic send_byte(input logic [7:0] c, input logic fin);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: c, is_last: fin};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 10) return 8'("0") + 8'(v);
      return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
   endfunction

   // \u escape whose code point needs one, two or three utf-8 bytes
   task automatic send_unicode();
      logic [15:0] cp;
      case ($urandom_range(0, 2))
         0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
         1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
         default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      send_text("\\u");
      for (int d = 3; d >= 0; d--) begin
         send_byte(hex_char(cp[d*4 +: 4], $urandom_range(0, 1)), 1'b0);
      end
   endtask

   // one broken spot inside an open string; the unit drops back to waiting
   task automatic send_fault();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0: begin
            // raw control byte
            send_byte(8'($urandom_range(0, 31)), 1'b0);
         end
         1: begin
            // unknown escape letter
            do c = 8'($urandom);
            while (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
            send_byte("\\", 1'b0);
            send_byte(c, 1'b0);
         end
         2: begin
            // non-hex byte somewhere in a \u escape
            send_text("\\u");
            repeat ($urandom_range(0, 3)) begin
               send_byte(hex_char(4'($urandom), $urandom_range(0, 1)), 1'b0);
            end
            do c = 8'($urandom); while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
            send_byte(c, 1'b0);
         end
         3: begin
            // buffer ends on an ordinary string byte
            do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == "\"");
            send_byte(c, 1'b1);
         end
         default: begin
            // buffer ends in the middle of an escape
            send_byte("\\", 1'b0);
            if ($urandom_range(0, 1)) begin
               send_byte(escape_letters[$urandom_range(0, 7)], 1'b1);
            end else begin
               send_byte("u", 1'b0);
               repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom), 1'b0), 1'b0);
               send_byte(hex_char(4'($urandom), 1'b1), 1'b1);
            end
         end
      endcase
   endtask

   // a whole string with random content; a broken one stops at a fault
   task automatic send_string(input bit broken);
      int         segments;
      int         fault_at;
      logic [7:0] c;
      req_no_idle = ($urandom_range(0, 3) == 0);
      rsp_no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 2)) send_byte(blank_bytes[$urandom_range(0, 3)], 1'b0);
      send_byte("\"", 1'b0);
      segments = $urandom_range(0, 6);
      fault_at = broken ? $urandom_range(0, segments) : -1;
      for (int i = 0; i < segments; i++) begin
         if (i == fault_at) break;
         case ($urandom_range(0, 2))
            0: begin
               do c = 8'($urandom_range(8'h20, 8'hFF)); while (c inside {"\"", "\\"});
               send_byte(c, 1'b0);
            end
            1: begin
               send_byte("\\", 1'b0);
               send_byte(escape_letters[$urandom_range(0, 7)], 1'b0);
            end
            default: send_unicode();
         endcase
      end
      if (broken) send_fault();
      else send_byte("\"", $urandom_range(0, 3) == 0);
   endtask

   // bytes between strings: whitespace, stray quotes and random garbage
   task automatic send_noise();
      logic [7:0] c;
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 2))
            0:       c = blank_bytes[$urandom_range(0, 3)];
            1:       c = "\"";
            default: c = 8'($urandom);
         endcase
         send_byte(c, $urandom_range(0, 2) == 0);
      end
   endtask

   initial begin
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: whitespace skip, extremes of the byte, zero and largest
      // code points, then some of the ways a string can go wrong
      send_byte(8'h09, 1'b0);
      send_byte("\"", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\\u0000");        // zero code point gives a 0x00 byte
      send_text("\\uFfFf");        // three-byte utf-8, mixed hex case
      send_byte(8'h1F, 1'b0);      // raw control byte inside the string
      send_text("\"\\q");          // unknown escape
      send_text("\"\\ug");         // bad hex digit
      send_byte("\"", 1'b0);
      send_byte("\"", 1'b1);       // closing quote on the last byte
      send_byte(8'h00, 1'b0);      // anything but a quote while waiting

      // random: mostly well-formed strings, some broken ones and noise
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         case ($urandom_range(0, 9))
            7, 8:    send_string(1'b1);
            9:       send_noise();
            default: send_string(1'b0);
         endcase
      end
      req_valid <= 1'b0;
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;

      // let the last transfer be counted, then drain
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("covered %0d text bytes: %0d decoded bytes, %0d strings closed, %0d errors",
               text_bytes, decoded_bytes, strings_closed, syntax_errors);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
